FILE: hw/rtl/case_folded_fnv1_hash_top_defines.svh
// Assertion macros shared by the case-folded FNV-1 hash checker.
`ifndef CASE_FOLDED_FNV1_HASH_TOP_DEFINES_SVH
`define CASE_FOLDED_FNV1_HASH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define CFH_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("cfh check failed");

// Next-cycle implication, disabled while dis is high.
`define CFH_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("cfh check failed");

`endif

FILE: hw/rtl/cfh_pkg.sv
// Types, constants and helper functions for the case-folded FNV-1 hash.
package cfh_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [HASH_W-1:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [HASH_W-1:0] LOW30_MASK = 32'd1073741823;
  localparam int unsigned       FOLD_SHIFT = 30;

  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              end_of_string;
  } item_t;

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] res;
    res = b;
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      res = b + CASE_OFFSET;
    end
    return res;
  endfunction

  // h * 16777619 mod 2^32; prime = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] prod;
    prod = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
    return prod ^ {{(HASH_W-BYTE_W){1'b0}}, fold_case(b)};
  endfunction

  function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h,
                                                    input logic full_width);
    logic [HASH_W-1:0] res;
    res = h;
    if (!full_width) begin
      res = (h >> FOLD_SHIFT) ^ (h & LOW30_MASK);
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/cfh_in_stage.sv
// Input register stage: holds one accepted word until the hash core takes it.
module cfh_in_stage
  import cfh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  assign in_ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hw/rtl/cfh_core.sv
// Hash core: running FNV-1 state, end-of-string fold and result register.
module cfh_core
  import cfh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  item_t             item,
  output logic              item_take,
  input  logic              full_width,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] out_hash_value
);

  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] hash_upd;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;

  // a word that closes a string needs a free result slot
  assign item_take = item_valid &&
                     (!item.end_of_string || !out_valid_r || out_ready);

  assign hash_upd = item.byte_present ? fnv_step(hash_r, item.data_byte) : hash_r;

  always_comb begin
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (item_take) begin
      if (item.end_of_string) begin
        hash_nxt      = FNV_BASIS;
        out_valid_nxt = 1'b1;
        out_hash_nxt  = finish_hash(hash_upd, full_width);
      end else begin
        hash_nxt = hash_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= FNV_BASIS;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

FILE: hw/rtl/case_folded_fnv1_hash_top.sv
// Case-folded 32-bit FNV-1 string hasher: takes one byte word per clock,
// folds ASCII A-Z to lower case, and returns one hash word per end-of-string
// word. Sustained rate is one input word per cycle; the limit is the
// running-hash register, which feeds back through the multiply-by-prime
// (shift-add) and XOR combinationally. A closing word waits in the input
// register only while an earlier hash word is still held unaccepted. A result
// passes the input register, then the result register, after its closing
// word is accepted; the closing word may wait between the two.
// full_width (reset 1) selects the full 32-bit hash or a 30-bit xor-fold;
// it is sampled when the closing word is processed.
module case_folded_fnv1_hash_top
  import cfh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_byte_present,
  input  logic              in_end_of_string,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] out_hash_value
);

  logic  full_width_r;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_width_r <= 1'b1;
    end else if (cfg_we) begin
      full_width_r <= cfg_wdata;
    end
  end

  assign in_item.data_byte     = in_data_byte;
  assign in_item.byte_present  = in_byte_present;
  assign in_item.end_of_string = in_end_of_string;

  cfh_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  cfh_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take),
    .full_width     (full_width_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule

FILE: hw/rtl/cfh_checker.sv
// Port-level checker for the case-folded FNV-1 hash, bound to the top level.
`include "case_folded_fnv1_hash_top_defines.svh"

module cfh_checker
  import cfh_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_we,
  input logic              cfg_wdata,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HASH_W-1:0] out_hash_value
);

  // shadow of the mode register as seen on the port
  logic fw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 1'b1;
    end else if (cfg_we) begin
      fw_r <= cfg_wdata;
    end
  end

  `CFH_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_hash_value))
  `CFH_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, !rst_n, !out_valid)
  `CFH_ASSERT_NOW(a_folded_top_zero, clk, !rst_n, out_valid && !fw_r, out_hash_value[31:30] == 2'b00)
  `CFH_ASSERT_NOW(a_ready_when_free, clk, !rst_n, !out_valid, in_ready)

endmodule

bind case_folded_fnv1_hash_top cfh_checker u_cfh_checker (.*);

FILE: test/tb_top.sv
// Self-checking testbench for the case-folded FNV-1 string hasher.
`timescale 1ns / 100ps

module tb_top
  import cfh_pkg::*;
();

  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_WORDS  = 600;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_byte_present;
  logic              in_end_of_string;
  logic              out_valid;
  logic              out_ready;
  logic [HASH_W-1:0] out_hash_value;

  // predictor state and expected hashes in arrival order
  logic [HASH_W-1:0] hash_state;
  logic              width_full;
  logic [HASH_W-1:0] pending_hashes[$];
  logic [HASH_W-1:0] want_hash;

  int  errors = 0;
  int  hashed_bytes = 0;
  int  closed_strings = 0;
  int  folded_closes = 0;
  int  checked_hashes = 0;
  int  real_words = 0;
  int  burst_left = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_stall_on = 1'b0;

  case_folded_fnv1_hash_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_byte_present  (in_byte_present),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hash_value   (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] lower_byte(input logic [BYTE_W-1:0] b);
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic logic [HASH_W-1:0] close_hash(input logic [HASH_W-1:0] h,
                                                   input logic full);
    if (full) begin
      return h;
    end
    return (h >> FOLD_SHIFT) ^ (h & LOW30_MASK);
  endfunction

  // one word on the input channel; predicts once it is accepted
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic present,
                           input logic last);
    @(negedge clk);
    in_valid         = 1'b1;
    in_data_byte     = b;
    in_byte_present  = present;
    in_end_of_string = last;
    do @(posedge clk); while (!in_ready);
    if (present) begin
      hash_state   = (hash_state * FNV_PRIME) ^ {24'd0, lower_byte(b)};
      hashed_bytes++;
    end
    if (last) begin
      pending_hashes = {pending_hashes, close_hash(hash_state, width_full)};
      hash_state = FNV_BASIS;
      closed_strings++;
      if (!width_full) begin
        folded_closes++;
      end
    end
    if (present || last) begin
      real_words++;
    end
  endtask

  task automatic gap(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // bursty sender: random burst length, random gap between bursts
  task automatic paced_word(input logic [BYTE_W-1:0] b, input logic present,
                            input logic last);
    if (tx_idle_on) begin
      if (burst_left == 0) begin
        gap($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    send_word(b, present, last);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic full);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = full;
    @(negedge clk);
    cfg_we    = 1'b0;
    width_full = full;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return ASCII_UPPER_A + BYTE_W'($urandom_range(0, 25));
    end else if (sel < 7) begin
      return 8'h61 + BYTE_W'($urandom_range(0, 25));
    end
    return BYTE_W'($urandom);
  endfunction

  // random string, idle words sprinkled in, closed by byte+end or empty close
  task automatic random_string();
    int len;
    int i;
    if ($urandom_range(0, 19) == 0) begin
      len = $urandom_range(30, 60);
    end else begin
      len = $urandom_range(0, 10);
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        paced_word(BYTE_W'($urandom), 1'b0, 1'b0);
      end
      paced_word(pick_byte(), 1'b1, 1'b0);
    end
    if (len > 0 && $urandom_range(0, 1) == 1) begin
      paced_word(pick_byte(), 1'b1, 1'b1);
    end else begin
      paced_word(BYTE_W'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic test_empty_close();
    send_word(8'h00, 1'b0, 1'b1);
    set_width(1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    set_width(1'b1);
  endtask

  task automatic test_case_fold();
    logic [BYTE_W-1:0] edges[8] = '{8'h40, 8'h41, 8'h5A, 8'h5B,
                                    8'h60, 8'h61, 8'h7A, 8'h7B};
    logic [BYTE_W-1:0] high_bytes[4] = '{8'h80, 8'hC1, 8'hDA, 8'hFF};
    foreach (edges[i]) send_word(edges[i], 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    foreach (high_bytes[i]) send_word(high_bytes[i], 1'b1, i == 3);
  endtask

  task automatic test_idle_words();
    send_word(8'h41, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h62, 1'b1, 1'b1);
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
  endtask

  // width is taken when the string closes, not when it starts
  task automatic test_width_mid_string();
    send_word(8'h48, 1'b1, 1'b0);
    send_word(8'h69, 1'b1, 1'b0);
    set_width(1'b0);
    send_word(8'h58, 1'b1, 1'b1);
    send_word(8'h7E, 1'b1, 1'b0);
    set_width(1'b1);
    send_word(8'hE9, 1'b1, 1'b1);
  endtask

  task automatic test_random_strings();
    int phase;
    int target;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_width(1'b1);
        1: set_width(1'b0);
        default: set_width(1'($urandom_range(0, 1)));
      endcase
      tx_idle_on  = (phase != 0 && phase != 4);
      rx_stall_on = (phase != 0 && phase != 3);
      target = real_words + RANDOM_WORDS / 6;
      while (real_words < target) begin
        random_string();
        // hold off mid-phase until everything is back out
        if (phase == 2 && real_words > target - RANDOM_WORDS / 12
            && real_words < target - RANDOM_WORDS / 12 + 12) begin
          drain();
        end
      end
    end
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
  endtask

  // receiver stalls on its own random 16-bit pattern
  initial begin
    logic [15:0] stall_bits;
    logic [3:0]  stall_pos;
    out_ready  = 1'b0;
    stall_bits = 16'hA5C3;
    stall_pos  = 4'd0;
    forever begin
      @(negedge clk);
      if (!rx_stall_on) begin
        out_ready = 1'b1;
      end else begin
        if (stall_pos == 4'd0) begin
          stall_bits = 16'($urandom);
          if (stall_bits == 16'd0) begin
            stall_bits = 16'd1;
          end
        end
        out_ready = stall_bits[stall_pos];
        stall_pos = stall_pos + 4'd1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash word, expected none, got %h", $time,
                 out_hash_value);
        errors++;
      end else begin
        want_hash = pending_hashes.pop_front();
        checked_hashes++;
        if (out_hash_value !== want_hash) begin
          $display("%0t: hash mismatch, expected %h, got %h", $time, want_hash,
                   out_hash_value);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d hashes outstanding", CYCLE_LIMIT,
             pending_hashes.size());
    $display("case_folded_fnv1_hash_top regression: fail");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = '0;
    in_byte_present  = 1'b0;
    in_end_of_string = 1'b0;
    hash_state       = FNV_BASIS;
    width_full       = 1'b1;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_empty_close();
    test_case_fold();
    test_idle_words();
    test_width_mid_string();
    test_random_strings();
    drain();

    $display("covered %0d strings (%0d folded to 30 bits), %0d bytes hashed",
             closed_strings, folded_closes, hashed_bytes);
    $display("%0d hash words checked, %0d errors", checked_hashes, errors);
    if (errors == 0) begin
      $display("case_folded_fnv1_hash_top regression: pass");
    end else begin
      $display("case_folded_fnv1_hash_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cfh_pkg.sv
hw/rtl/cfh_in_stage.sv
hw/rtl/cfh_core.sv
hw/rtl/case_folded_fnv1_hash_top.sv
hw/rtl/cfh_checker.sv
test/tb_top.sv
